FILE: sv/prtp_pkg.sv
// ----------------------------------------------------------------------------
// prtp_pkg
// Shared constants for the port range to ternary prefix expansion block.
// ----------------------------------------------------------------------------
package prtp_pkg;

    localparam int PORT_WIDTH_DEF = 16;
    localparam int INDEX_W        = 5;
    localparam int QDEPTH         = 2;

endpackage

FILE: sv/prtp_ifs.sv
// ----------------------------------------------------------------------------
// prtp_ifs
// Valid/ready channels for range items in and prefix entries out.
// ----------------------------------------------------------------------------
interface prtp_in_if #(
    parameter int PORT_WIDTH = prtp_pkg::PORT_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PORT_WIDTH-1:0] range_low;
    logic [PORT_WIDTH-1:0] range_high;

    modport source (output valid, range_low, range_high, input ready);
    modport sink   (input valid, range_low, range_high, output ready);
endinterface

interface prtp_out_if #(
    parameter int PORT_WIDTH = prtp_pkg::PORT_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic [PORT_WIDTH-1:0]       entry_value;
    logic [PORT_WIDTH-1:0]       entry_mask;
    logic [prtp_pkg::INDEX_W-1:0] entry_index;
    logic                        last_entry;
    logic                        range_empty;

    modport source (output valid, entry_value, entry_mask, entry_index, last_entry,
                    range_empty, input ready);
    modport sink   (input valid, entry_value, entry_mask, entry_index, last_entry,
                    range_empty, output ready);
endinterface

FILE: sv/port_range_to_tcam_prefixes.sv
// ----------------------------------------------------------------------------
// port_range_to_tcam_prefixes
// Expands one inclusive port range into the value/mask prefixes covering it.
// ----------------------------------------------------------------------------
// Each range item yields its prefixes in order, one entry per cycle while
// the consumer keeps up, with mask bits of 1 meaning compared bits, an index
// from 0 and a last flag; a reversed range yields a single entry flagged
// empty. For each range the expansion sequencer pops the queue, walks the
// downward run one entry at a time until it ends at zero or on a prefix
// below the low bound, turns to the upward run, walks it, and flushes the
// held-back final entry. It takes no new range until that flush is done.
// The classifier and a two-deep queue take following ranges while the
// sequencer works, and the output register lets the sequencer run one
// entry ahead of a stalled consumer.
// ----------------------------------------------------------------------------
module port_range_to_tcam_prefixes #(
    parameter int PORT_WIDTH = prtp_pkg::PORT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prtp_in_if.sink     i_in,
    prtp_out_if.source  o_out
);
    localparam int JOB_W = 5 * PORT_WIDTH + 2;

    logic             f_valid;
    logic             f_ready;
    logic [JOB_W-1:0] f_job;
    logic             q_valid;
    logic             q_ready;
    logic [JOB_W-1:0] q_job;

    prtp_front #(
        .PORT_WIDTH(PORT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    prtp_fifo #(
        .DATA_W(JOB_W)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_data  (f_job),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_job)
    );

    prtp_back #(
        .PORT_WIDTH(PORT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_out       (o_out)
    );

endmodule

FILE: sv/prtp_front.sv
// ----------------------------------------------------------------------------
// prtp_front
// Accepts a range item, classifies it and prepares the start of the
// downward run: high bound with trailing ones dropped, its mask and the
// first open bit, plus the lowest set bit of the low bound.
// ----------------------------------------------------------------------------
module prtp_front #(
    parameter int PORT_WIDTH = prtp_pkg::PORT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    prtp_in_if.sink                   i_in,
    output logic                      o_job_valid,
    input  logic                      i_job_ready,
    output logic [5*PORT_WIDTH+1:0]   o_job
);
    localparam int W   = PORT_WIDTH;
    localparam int WP1 = PORT_WIDTH + 1;

    typedef struct packed {
        logic         empty;
        logic [W-1:0] lo;
        logic [W-1:0] port;
        logic [W-1:0] mask;
        logic [W-1:0] lz;
        logic [W:0]   hbit;
    } t_job;

    t_job         n_job;
    t_job         r_job;
    logic         r_valid;
    logic [W-1:0] hi_inc;
    logic [W-1:0] trail_ones;

    always_comb begin
        hi_inc       = i_in.range_high + W'(1);
        trail_ones   = i_in.range_high & ~hi_inc;
        n_job.empty  = i_in.range_low > i_in.range_high;
        n_job.lo     = i_in.range_low;
        n_job.port   = i_in.range_high & hi_inc;
        n_job.mask   = ~trail_ones;
        n_job.hbit   = {1'b0, trail_ones} + WP1'(1);
        n_job.lz     = i_in.range_low & (~i_in.range_low + W'(1));
    end

    assign i_in.ready  = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_job <= n_job;
        end
    end

endmodule

FILE: sv/prtp_fifo.sv
// ----------------------------------------------------------------------------
// prtp_fifo
// Short queue between the classifier and the expansion sequencer.
// ----------------------------------------------------------------------------
module prtp_fifo #(
    parameter int DATA_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_valid,
    output logic              o_wr_ready,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic              o_rd_valid,
    input  logic              i_rd_ready,
    output logic [DATA_W-1:0] o_rd_data
);
    localparam int DEPTH = prtp_pkg::QDEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              push;
    logic              pop;

    assign o_wr_ready = r_cnt < CNT_W'(DEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: sv/prtp_back.sv
// ----------------------------------------------------------------------------
// prtp_back
// Expansion sequencer: walks the downward run from the high bound, then the
// upward run from the low bound, one prefix per cycle unless stalled. One
// entry is held back to flag the last, then passed to the output register.
// ----------------------------------------------------------------------------
module prtp_back #(
    parameter int PORT_WIDTH = prtp_pkg::PORT_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_job_valid,
    output logic                    o_job_ready,
    input  logic [5*PORT_WIDTH+1:0] i_job,
    prtp_out_if.source              o_out
);
    localparam int W       = PORT_WIDTH;
    localparam int WP1     = PORT_WIDTH + 1;
    localparam int MAX_ENT = 2 * PORT_WIDTH - 2;
    localparam int CNT_W   = $clog2(2 * PORT_WIDTH - 1);
    localparam int IDX_W   = prtp_pkg::INDEX_W;

    typedef struct packed {
        logic         empty;
        logic [W-1:0] lo;
        logic [W-1:0] port;
        logic [W-1:0] mask;
        logic [W-1:0] lz;
        logic [W:0]   hbit;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOWN,
        S_UP_INIT,
        S_UP,
        S_FLUSH
    } t_state;

    t_job             job;
    t_state           r_state, n_state;
    logic [W-1:0]     r_lo, n_lo;
    logic [W-1:0]     r_lz, n_lz;
    logic [W-1:0]     r_port, n_port;
    logic [W-1:0]     r_mask, n_mask;
    logic [W:0]       r_hbit, n_hbit;
    logic [W:0]       r_lbit, n_lbit;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_pv, n_pv;
    logic             r_pempty, n_pempty;
    logic [W-1:0]     r_pval, n_pval;
    logic [W-1:0]     r_pmask, n_pmask;
    logic [CNT_W-1:0] r_pidx, n_pidx;
    logic             r_ov, n_ov;
    logic [W-1:0]     r_oval, n_oval;
    logic [W-1:0]     r_omask, n_omask;
    logic [IDX_W-1:0] r_oidx, n_oidx;
    logic             r_olast, n_olast;
    logic             r_oempty, n_oempty;

    logic             out_free;
    logic             room;
    logic             down_hit;
    logic [W-1:0]     d_low;
    logic [W:0]       u_sum;
    logic [W:0]       u_low;
    logic             u_done;
    logic             lz_ok;
    logic             want_emit;
    logic             stall;

    assign job      = t_job'(i_job);
    assign out_free = !r_ov || o_out.ready;
    assign room     = r_count < CNT_W'(MAX_ENT);
    assign down_hit = r_port >= r_lo;
    assign d_low    = r_port & (~r_port + W'(1));
    assign u_sum    = {1'b0, r_port} + r_lbit;
    assign u_low    = u_sum & (~u_sum + WP1'(1));
    assign u_done   = u_low >= r_hbit;
    assign lz_ok    = (r_lz != '0) && ({1'b0, r_lz} < r_hbit);

    assign o_job_ready = r_state == S_IDLE;

    always_comb begin
        want_emit = 1'b0;
        case (r_state)
            S_DOWN:  want_emit = down_hit && room;
            S_UP:    want_emit = room;
            default: want_emit = 1'b0;
        endcase
        stall = want_emit && r_pv && !out_free;
    end

    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_lz     = r_lz;
        n_port   = r_port;
        n_mask   = r_mask;
        n_hbit   = r_hbit;
        n_lbit   = r_lbit;
        n_count  = r_count;
        n_pv     = r_pv;
        n_pempty = r_pempty;
        n_pval   = r_pval;
        n_pmask  = r_pmask;
        n_pidx   = r_pidx;
        n_ov     = r_ov && !o_out.ready;
        n_oval   = r_oval;
        n_omask  = r_omask;
        n_oidx   = r_oidx;
        n_olast  = r_olast;
        n_oempty = r_oempty;

        if (want_emit && !stall) begin
            if (r_pv) begin
                n_ov     = 1'b1;
                n_oval   = r_pval;
                n_omask  = r_pmask;
                n_oidx   = IDX_W'(r_pidx);
                n_olast  = 1'b0;
                n_oempty = r_pempty;
            end
            n_pv    = 1'b1;
            n_pval  = r_port;
            n_pmask = r_mask;
            n_pidx  = r_count;
            n_count = r_count + CNT_W'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_lo    = job.lo;
                    n_lz    = job.lz;
                    n_port  = job.port;
                    n_mask  = job.mask;
                    n_hbit  = job.hbit;
                    n_count = '0;
                    if (job.empty) begin
                        n_pv     = 1'b1;
                        n_pempty = 1'b1;
                        n_pval   = '0;
                        n_pmask  = '0;
                        n_pidx   = '0;
                        n_state  = S_FLUSH;
                    end else begin
                        n_pempty = 1'b0;
                        n_state  = S_DOWN;
                    end
                end
            end
            S_DOWN: begin
                if (!stall) begin
                    if (!down_hit) begin
                        n_state = S_UP_INIT;
                    end else if (r_port == '0) begin
                        n_hbit  = {1'b1, {W{1'b0}}};
                        n_state = S_UP_INIT;
                    end else begin
                        n_mask = ~(d_low - W'(1));
                        n_hbit = {1'b0, d_low};
                        n_port = r_port & ~d_low;
                    end
                end
            end
            S_UP_INIT: begin
                if (lz_ok) begin
                    n_port  = r_lo;
                    n_mask  = ~(r_lz - W'(1));
                    n_lbit  = {1'b0, r_lz};
                    n_state = S_UP;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_UP: begin
                if (!stall) begin
                    if (u_done) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_port = u_sum[W-1:0];
                        n_mask = ~(u_low[W-1:0] - W'(1));
                        n_lbit = u_low;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov     = 1'b1;
                    n_oval   = r_pval;
                    n_omask  = r_pmask;
                    n_oidx   = IDX_W'(r_pidx);
                    n_olast  = 1'b1;
                    n_oempty = r_pempty;
                    n_pv     = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
            r_count <= n_count;
        end
        r_lo     <= n_lo;
        r_lz     <= n_lz;
        r_port   <= n_port;
        r_mask   <= n_mask;
        r_hbit   <= n_hbit;
        r_lbit   <= n_lbit;
        r_pempty <= n_pempty;
        r_pval   <= n_pval;
        r_pmask  <= n_pmask;
        r_pidx   <= n_pidx;
        r_oval   <= n_oval;
        r_omask  <= n_omask;
        r_oidx   <= n_oidx;
        r_olast  <= n_olast;
        r_oempty <= n_oempty;
    end

    assign o_out.valid       = r_ov;
    assign o_out.entry_value = r_oval;
    assign o_out.entry_mask  = r_omask;
    assign o_out.entry_index = r_oidx;
    assign o_out.last_entry  = r_olast;
    assign o_out.range_empty = r_oempty;

endmodule

FILE: sv/prtp_chk.sv
// ----------------------------------------------------------------------------
// prtp_chk
// Port-level checks on the prefix entry stream, bound to the top level.
// ----------------------------------------------------------------------------
module prtp_chk #(
    parameter int PORT_WIDTH = prtp_pkg::PORT_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [PORT_WIDTH-1:0]        i_entry_value,
    input logic [PORT_WIDTH-1:0]        i_entry_mask,
    input logic [prtp_pkg::INDEX_W-1:0] i_entry_index,
    input logic                         i_last_entry,
    input logic                         i_range_empty
);
    localparam int IDX_W = prtp_pkg::INDEX_W;

    logic [IDX_W-1:0] r_exp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_exp_idx <= i_last_entry ? '0 : i_entry_index + IDX_W'(1);
        end
    end

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_entry_value)
            && $stable(i_entry_mask) && $stable(i_entry_index)
            && $stable(i_last_entry) && $stable(i_range_empty))
        else $error("stalled entry changed");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_range_empty |-> i_last_entry && i_entry_index == '0
            && i_entry_value == '0 && i_entry_mask == '0)
        else $error("empty result malformed");

    a_index_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_entry_index == r_exp_idx)
        else $error("entry index out of sequence");

    a_value_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_range_empty |-> (i_entry_value & ~i_entry_mask) == '0)
        else $error("value has bits outside care mask");

endmodule

bind port_range_to_tcam_prefixes prtp_chk #(
    .PORT_WIDTH(PORT_WIDTH)
) u_prtp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_entry_value (o_out.entry_value),
    .i_entry_mask  (o_out.entry_mask),
    .i_entry_index (o_out.entry_index),
    .i_last_entry  (o_out.last_entry),
    .i_range_empty (o_out.range_empty)
);
